@@ sv/icm_pkg.sv @@
// Types, formats and coefficient tables shared by the Ic magnitude pipeline.
`default_nettype none
package icm_pkg;

  localparam int MAG_WIDTH = 24;
  localparam int FRAC_BITS = 16;
  localparam int COEF_FRAC = 24;
  localparam int COEF_W    = 32;
  localparam int SPLIT_W   = 23;
  localparam logic [SPLIT_W-1:0] SPLIT_RESET = SPLIT_W'(229376);

  // Q.24 scaling of the color term
  localparam int UP   = (FRAC_BITS <= COEF_FRAC) ? COEF_FRAC - FRAC_BITS : 0;
  localparam int DOWN = (FRAC_BITS > COEF_FRAC) ? FRAC_BITS - COEF_FRAC : 0;

  // accumulator is clamped to +-2^ACC_LIM_LOG
  localparam int ACC_LIM_LOG = 35;
  localparam int ACC_W       = ACC_LIM_LOG + 2;
  // x is clamped to +-8.0, that is +-2^(COEF_FRAC+3) in Q.24
  localparam int XQ_W        = COEF_FRAC + 5;
  // accumulator split for the two partial products
  localparam int LO_W        = 18;
  localparam int HI_W        = ACC_W - LO_W;
  localparam int PROD_W      = HI_W + XQ_W;
  localparam int SUM_W       = ACC_W + XQ_W + 2;
  localparam int STEPS       = 7;

  // c1 .. c8 at index 0 .. 7, Q.24
  localparam logic signed [COEF_W-1:0] GIANT_COEF [8] = '{
    -32'sd148975,   32'sd12399549,  32'sd5488633,   32'sd19128862,
    -32'sd3202162,  -32'sd13252028, 32'sd8708623,   -32'sd8990689
  };
  localparam logic signed [COEF_W-1:0] DWARF_COEF [8] = '{
    32'sd1494278,   32'sd22140473,  32'sd7485670,   -32'sd19933463,
    32'sd4136543,   32'sd142247757, 32'sd175590175, 32'sd61089635
  };

  typedef struct packed {
    logic signed [MAG_WIDTH-1:0] b_mag;
    logic signed [MAG_WIDTH-1:0] v_mag;
    logic signed [MAG_WIDTH-1:0] log_gravity;
  } star_t;

  typedef struct packed {
    logic signed [MAG_WIDTH-1:0] ic_mag;
    logic                        used_giant_set;
  } result_t;

  // between Horner steps
  typedef struct packed {
    logic                        giant;
    logic signed [MAG_WIDTH-1:0] v_mag;
    logic signed [XQ_W-1:0]      xq;
    logic signed [ACC_W-1:0]     acc;
  } horner_t;

  // inside a Horner step, after the partial products
  typedef struct packed {
    logic                        giant;
    logic signed [MAG_WIDTH-1:0] v_mag;
    logic signed [XQ_W-1:0]      xq;
    logic signed [PROD_W-1:0]    hi_prod;
    logic signed [PROD_W-1:0]    lo_prod;
  } prod_t;

endpackage
`default_nettype wire

@@ sv/icm_front.sv @@
// Front stage: gravity compare, color term, clamp and Q.24 conversion.
`default_nettype none
module icm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [icm_pkg::SPLIT_W-1:0]   gravity_split,
  input  wire logic                          star_valid,
  output logic                               star_ready,
  input  wire icm_pkg::star_t                star,
  output logic                               head_valid,
  input  wire logic                          head_ready,
  output icm_pkg::horner_t                   head
);

  localparam int MW   = icm_pkg::MAG_WIDTH;
  localparam int FB   = icm_pkg::FRAC_BITS;
  localparam int D_W  = ((MW > FB + 4) ? MW : FB + 4) + 2;
  localparam int X_W  = D_W + icm_pkg::UP;
  localparam int CMP_W = ((MW > icm_pkg::SPLIT_W) ? MW : icm_pkg::SPLIT_W) + 1;
  localparam logic signed [D_W-1:0] ONE  = D_W'(64'sd1 <<< FB);
  localparam logic signed [D_W-1:0] XLIM = D_W'(64'sd8 <<< FB);
  localparam logic signed [X_W-1:0] XRND =
    (icm_pkg::DOWN > 0) ? X_W'(64'sd1 <<< (icm_pkg::DOWN - 1)) : '0;
  localparam logic signed [icm_pkg::XQ_W-1:0] XQ_LIM =
    icm_pkg::XQ_W'(64'sd8 <<< icm_pkg::COEF_FRAC);

  logic signed [CMP_W-1:0]         g_ext;
  logic signed [CMP_W-1:0]         split_ext;
  logic                            giant;
  logic signed [D_W-1:0]           diff;
  logic signed [D_W-1:0]           x;
  logic signed [X_W-1:0]           x_ext;
  logic signed [X_W-1:0]           xq_wide;
  icm_pkg::horner_t                head_next;

  always_comb begin
    g_ext     = CMP_W'(star.log_gravity);
    split_ext = $signed(CMP_W'(gravity_split));
    giant     = g_ext < split_ext;
    diff      = D_W'(star.b_mag) - D_W'(star.v_mag) - ONE;
    if (diff > XLIM) begin
      x = XLIM;
    end else if (diff < -XLIM) begin
      x = -XLIM;
    end else begin
      x = diff;
    end
    x_ext = X_W'(x);
    if (icm_pkg::DOWN > 0) begin
      xq_wide = (x_ext + XRND) >>> icm_pkg::DOWN;
    end else begin
      xq_wide = x_ext <<< icm_pkg::UP;
    end
    head_next.giant = giant;
    head_next.v_mag = star.v_mag;
    head_next.xq    = icm_pkg::XQ_W'(xq_wide);
    head_next.acc   = giant ? icm_pkg::ACC_W'(icm_pkg::GIANT_COEF[7])
                            : icm_pkg::ACC_W'(icm_pkg::DWARF_COEF[7]);
  end

  assign star_ready = !head_valid || head_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (star_ready) begin
      head_valid <= star_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (star_ready && star_valid) begin
      head <= head_next;
    end
  end

  a_xq_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head.xq <= XQ_LIM && head.xq >= -XQ_LIM))
    else $error("color term outside clamp range");

endmodule
`default_nettype wire

@@ sv/icm_horner_step.sv @@
// One Horner step: split multiply, then round, add coefficient and clamp.
`default_nettype none
module icm_horner_step #(
  parameter int K = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire icm_pkg::horner_t  up,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output icm_pkg::horner_t       dn
);

  localparam int SW = icm_pkg::SUM_W;
  localparam int CF = icm_pkg::COEF_FRAC;
  // coefficient moved to Q.48 plus the rounding half
  localparam logic signed [SW-1:0] G_ADD =
    (SW'(icm_pkg::GIANT_COEF[K]) <<< CF) + SW'(64'sd1 <<< (CF - 1));
  localparam logic signed [SW-1:0] D_ADD =
    (SW'(icm_pkg::DWARF_COEF[K]) <<< CF) + SW'(64'sd1 <<< (CF - 1));
  localparam int RS_W = SW - CF;
  localparam logic signed [RS_W-1:0] LIM = RS_W'(64'sd1 <<< icm_pkg::ACC_LIM_LOG);
  localparam logic signed [icm_pkg::ACC_W-1:0] ACC_LIM =
    icm_pkg::ACC_W'(64'sd1 <<< icm_pkg::ACC_LIM_LOG);

  logic                                 m_valid;
  logic                                 m_ready;
  icm_pkg::prod_t                       m;
  icm_pkg::prod_t                       m_next;
  logic signed [icm_pkg::HI_W-1:0]      acc_hi;
  logic signed [icm_pkg::LO_W:0]        acc_lo;
  logic signed [SW-1:0]                 sum;
  logic signed [RS_W-1:0]               rs;
  icm_pkg::horner_t                     dn_next;

  always_comb begin
    acc_hi         = up.acc[icm_pkg::ACC_W-1:icm_pkg::LO_W];
    acc_lo         = $signed({1'b0, up.acc[icm_pkg::LO_W-1:0]});
    m_next.giant   = up.giant;
    m_next.v_mag   = up.v_mag;
    m_next.xq      = up.xq;
    m_next.hi_prod = icm_pkg::PROD_W'(acc_hi) * icm_pkg::PROD_W'(up.xq);
    m_next.lo_prod = icm_pkg::PROD_W'(acc_lo) * icm_pkg::PROD_W'(up.xq);
  end

  assign up_ready = !m_valid || m_ready;
  assign m_ready  = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (up_ready) begin
      m_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      m <= m_next;
    end
  end

  always_comb begin
    sum = (SW'(m.hi_prod) <<< icm_pkg::LO_W) + SW'(m.lo_prod)
        + (m.giant ? G_ADD : D_ADD);
    rs  = sum[SW-1:CF];
    dn_next.giant = m.giant;
    dn_next.v_mag = m.v_mag;
    dn_next.xq    = m.xq;
    if (rs > LIM) begin
      dn_next.acc = ACC_LIM;
    end else if (rs < -LIM) begin
      dn_next.acc = -ACC_LIM;
    end else begin
      dn_next.acc = icm_pkg::ACC_W'(rs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (m_ready) begin
      dn_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && m_valid) begin
      dn <= dn_next;
    end
  end

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    dn_valid |-> (dn.acc <= ACC_LIM && dn.acc >= -ACC_LIM))
    else $error("accumulator outside clamp range");

  a_mult_moves: assert property (@(posedge clk) disable iff (rst)
    m_valid && m_ready |=> dn_valid)
    else $error("product stage request lost");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_ready |=> dn_valid && $stable(dn))
    else $error("stalled step output changed");

endmodule
`default_nettype wire

@@ sv/icm_back.sv @@
// Output stage: back to Q.FRAC_BITS, Ic = V - y - 1, saturation.
`default_nettype none
module icm_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tail_valid,
  output logic                   tail_ready,
  input  wire icm_pkg::horner_t  tail,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output icm_pkg::result_t       result
);

  localparam int MW   = icm_pkg::MAG_WIDTH;
  localparam int FB   = icm_pkg::FRAC_BITS;
  localparam int Y_W  = icm_pkg::ACC_W + icm_pkg::DOWN + 1;
  localparam int IC_W = ((MW > Y_W) ? MW : Y_W) + 2;
  localparam logic signed [Y_W-1:0] YRND =
    (icm_pkg::UP > 0) ? Y_W'(64'sd1 <<< (icm_pkg::UP - 1)) : '0;
  localparam logic signed [IC_W-1:0] ONE   = IC_W'(64'sd1 <<< FB);
  localparam logic signed [IC_W-1:0] IC_HI = IC_W'((64'sd1 <<< (MW - 1)) - 64'sd1);
  localparam logic signed [IC_W-1:0] IC_LO = -IC_HI - IC_W'(1);

  logic signed [Y_W-1:0]  acc_ext;
  logic signed [Y_W-1:0]  yf;
  logic signed [IC_W-1:0] ic;
  icm_pkg::result_t       result_next;

  always_comb begin
    acc_ext = Y_W'(tail.acc);
    if (icm_pkg::UP > 0) begin
      yf = (acc_ext + YRND) >>> icm_pkg::UP;
    end else begin
      yf = acc_ext <<< icm_pkg::DOWN;
    end
    ic = IC_W'(tail.v_mag) - IC_W'(yf) - ONE;
    if (ic > IC_HI) begin
      result_next.ic_mag = MW'(IC_HI);
    end else if (ic < IC_LO) begin
      result_next.ic_mag = MW'(IC_LO);
    end else begin
      result_next.ic_mag = MW'(ic);
    end
    result_next.used_giant_set = tail.giant;
  end

  assign tail_ready = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tail_ready) begin
      result_valid <= tail_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_ready && tail_valid) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/ic_magnitude_from_bv_polynomial.sv @@
// Top level: Cousins I magnitude from B, V and log g via a pipelined Horner chain.
//
//   channel  direction  handshake                 payload
//   star     in         star_valid / star_ready     icm_pkg::star_t
//   result   out        result_valid / result_ready icm_pkg::result_t
//   cfg      in         cfg_valid / cfg_ready       gravity_split, 23 bit
//
// One star per cycle unless the output stalls; front stage, seven Horner steps
// of two stages each (split multiply, then round/add/clamp), output stage.
// Each stage has its own valid bit and takes a new request when empty or
// when its successor takes its content, so bubbles close up under a stall.
// Reset clears all valid bits and loads gravity_split with 3.5.
`default_nettype none
module ic_magnitude_from_bv_polynomial (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [icm_pkg::SPLIT_W-1:0]  cfg_data,
  input  wire logic                         star_valid,
  output logic                              star_ready,
  input  wire icm_pkg::star_t               star,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output icm_pkg::result_t                  result
);

  localparam int N = icm_pkg::STEPS;

  logic [icm_pkg::SPLIT_W-1:0] gravity_split;
  logic                        chain_valid [N+1];
  logic                        chain_ready [N+1];
  icm_pkg::horner_t            chain       [N+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_split <= icm_pkg::SPLIT_RESET;
    end else if (cfg_valid) begin
      gravity_split <= cfg_data;
    end
  end

  icm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .gravity_split (gravity_split),
    .star_valid    (star_valid),
    .star_ready    (star_ready),
    .star          (star),
    .head_valid    (chain_valid[0]),
    .head_ready    (chain_ready[0]),
    .head          (chain[0])
  );

  // step i applies coefficient c(7-i), index N-1-i
  for (genvar i = 0; i < N; i++) begin : g_step
    icm_horner_step #(
      .K (N - 1 - i)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up       (chain[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn       (chain[i+1])
    );
  end

  icm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tail_valid   (chain_valid[N]),
    .tail_ready   (chain_ready[N]),
    .tail         (chain[N]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

@@ bench/ic_magnitude_checker.sv @@
// Checker for the Ic magnitude block: predicts each result from B, V, log g and compares.
module ic_magnitude_checker
  import icm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [SPLIT_W-1:0] cfg_data,
  input  logic               star_valid,
  input  logic               star_ready,
  input  star_t              star,
  input  logic               result_valid,
  input  logic               result_ready,
  input  result_t            result,
  output int                 pending,
  output int                 mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SPLIT_W-1:0] SPLIT_AT_RESET = 23'd229376;  // log g 3.5
  localparam longint ONE_Q16   = 64'sd65536;
  localparam longint COLOR_LIM = 64'sd524288;        // +-8.0 in Q.16
  localparam longint POLY_LIM  = 64'sd34359738368;   // +-2048.0 in Q.24
  localparam longint IC_MAX    = 64'sd8388607;
  localparam longint IC_MIN    = -64'sd8388608;

  // c1 .. c8, Q.24
  localparam longint GIANT_TERMS [8] = '{
    -64'sd148975, 64'sd12399549, 64'sd5488633, 64'sd19128862,
    -64'sd3202162, -64'sd13252028, 64'sd8708623, -64'sd8990689
  };
  localparam longint DWARF_TERMS [8] = '{
    64'sd1494278, 64'sd22140473, 64'sd7485670, -64'sd19933463,
    64'sd4136543, 64'sd142247757, 64'sd175590175, 64'sd61089635
  };

  logic [SPLIT_W-1:0] split_copy;
  result_t            expected_ic [$];

  initial mismatch_count = 0;

  function automatic result_t predict_ic_mag(star_t s, logic [SPLIT_W-1:0] split);
    longint  b;
    longint  v;
    longint  color;
    longint  acc;
    longint  ic;
    bit      giant;
    result_t r;
    b = longint'(s.b_mag);
    v = longint'(s.v_mag);
    giant = longint'(s.log_gravity) < longint'(split);
    color = b - v - ONE_Q16;
    if (color > COLOR_LIM) color = COLOR_LIM;
    if (color < -COLOR_LIM) color = -COLOR_LIM;
    color = color * 256;  // Q.16 -> Q.24
    acc = giant ? GIANT_TERMS[7] : DWARF_TERMS[7];
    for (int k = 6; k >= 0; k--) begin
      acc = ((acc * color + 64'sd8388608) >>> 24) + (giant ? GIANT_TERMS[k] : DWARF_TERMS[k]);
      if (acc > POLY_LIM) acc = POLY_LIM;
      if (acc < -POLY_LIM) acc = -POLY_LIM;
    end
    ic = v - ((acc + 64'sd128) >>> 8) - ONE_Q16;
    if (ic > IC_MAX) ic = IC_MAX;
    if (ic < IC_MIN) ic = IC_MIN;
    r.ic_mag = ic[MAG_WIDTH-1:0];
    r.used_giant_set = giant;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      split_copy <= SPLIT_AT_RESET;
      expected_ic.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        split_copy <= cfg_data;
      if (star_valid && star_ready)
        expected_ic = {expected_ic, predict_ic_mag(star, split_copy)};
      if (result_valid && result_ready) begin
        if (expected_ic.size() == 0) begin
          report_mismatch("result without request", longint'(result.ic_mag), 0);
        end else begin
          want = expected_ic.pop_front();
          if (result.ic_mag !== want.ic_mag)
            report_mismatch("ic_mag", longint'(result.ic_mag), longint'(want.ic_mag));
          if (result.used_giant_set !== want.used_giant_set)
            report_mismatch("used_giant_set", longint'(result.used_giant_set),
                            longint'(want.used_giant_set));
        end
      end
      pending <= expected_ic.size();
    end
  end

endmodule

@@ bench/tb_ic_magnitude_from_bv_polynomial.sv @@
// Testbench top: star stimulus, result sink, gravity split writes, watchdog and verdict.
module tb_ic_magnitude_from_bv_polynomial;
  timeunit 1ns;
  timeprecision 1ps;
  import icm_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SPLIT_W-1:0] cfg_data = '0;
  logic               star_valid = 1'b0;
  logic               star_ready;
  star_t              star = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_t            result;

  int                 pending;
  int                 mismatch_count;
  int                 quiet_cycles = 0;
  int                 stars_sent = 0;
  bit                 sender_steady = 1'b0;
  bit                 receiver_steady = 1'b0;
  logic [SPLIT_W-1:0] split_now = 23'd229376;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ic_magnitude_from_bv_polynomial dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .star_valid   (star_valid),
    .star_ready   (star_ready),
    .star         (star),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  ic_magnitude_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .star_valid     (star_valid),
    .star_ready     (star_ready),
    .star           (star),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .pending        (pending),
    .mismatch_count (mismatch_count)
  );

  function automatic star_t mk_star(int b, int v, int g);
    star_t s;
    s.b_mag = 24'(b);
    s.v_mag = 24'(v);
    s.log_gravity = 24'(g);
    return s;
  endfunction

  // mostly plausible stars around the split, the rest raw bits
  function automatic star_t rand_star(logic [SPLIT_W-1:0] split);
    star_t s;
    int    v;
    int    color;
    int    g;
    if ($urandom_range(0, 9) < 7) begin
      v = int'($urandom_range(0, 40 << 16)) - (5 << 16);
      if ($urandom_range(0, 7) == 0)
        color = int'($urandom_range(0, 24 << 16)) - (12 << 16);
      else
        color = int'($urandom_range(0, 4 << 16)) - (1 << 16);
      case ($urandom_range(0, 2))
        0: g = int'(split) + int'($urandom_range(0, 2)) - 1;
        1: g = int'($urandom_range(0, 6 << 16));
        default: g = int'(split) + int'($urandom_range(0, 1 << 17)) - (1 << 16);
      endcase
      s = mk_star(v + color, v, g);
    end else begin
      s.b_mag = 24'($urandom);
      s.v_mag = 24'($urandom);
      s.log_gravity = 24'($urandom);
    end
    return s;
  endfunction

  task automatic send_star(star_t s);
    int gap;
    if (stars_sent % 40 == 0)
      sender_steady = ($urandom_range(0, 3) == 0);
    stars_sent++;
    gap = sender_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      star_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    star_valid <= 1'b1;
    star <= s;
    do @(posedge clk); while (!star_ready);
  endtask

  // hold requests until every result is back, then let the pipeline settle
  task automatic drain_pipeline();
    star_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_gravity_split(logic [SPLIT_W-1:0] value);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    split_now = value;
  endtask

  always @(posedge clk) begin
    if (rst || (star_valid && star_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("ic_magnitude_from_bv_polynomial verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    @(negedge rst);
    forever begin
      if (taken % 40 == 0)
        receiver_steady = ($urandom_range(0, 3) == 0);
      taken++;
      stall = receiver_steady ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // split at its reset value, 3.5
    send_star(mk_star(0, 0, 0));
    send_star(mk_star(65536, 0, 229376));            // color zero, g on the split
    send_star(mk_star(65536, 0, 229375));            // just below the split
    send_star(mk_star(0, 0, -8388608));              // negative gravity
    send_star(mk_star(0, 0, 8388607));
    send_star(mk_star(8388607, -8388608, 262144));   // color clamped high
    send_star(mk_star(8388607, -8388608, 65536));
    send_star(mk_star(-8388608, 8388607, 262144));   // color clamped low
    send_star(mk_star(-8388608, 8388607, 65536));
    send_star(mk_star(8388607, 8388607, 290980));
    send_star(mk_star(-8388608, -8388608, 131072));
    send_star(mk_star(-1, -1, -1));
    send_star(mk_star(358137, 316539, 290980));      // solar type dwarf
    send_star(mk_star(144179, 65536, 131072));       // red giant
    send_star(mk_star(589824, 0, 262144));           // color exactly +8
    send_star(mk_star(589823, 0, 131072));
    send_star(mk_star(-458752, 0, 262144));          // color exactly -8
    send_star(mk_star(-458751, 0, 131072));
    send_star(mk_star(-8323072, -8388608, 262144));  // saturates low
    send_star(mk_star(8191999, 8388607, 262144));    // saturates high
    send_star(mk_star(100000, 100000, 300000));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_gravity_split(23'd0);
        1: write_gravity_split(23'h7FFFFF);
        2: write_gravity_split(23'($urandom_range(0, 6 << 16)));
        3: write_gravity_split(23'd294912);
        4: write_gravity_split(23'($urandom));
        default: write_gravity_split(23'd229376);
      endcase
      for (int n = 0; n < 75; n++) begin
        if (n == 37 && phase % 2 == 1)
          drain_pipeline();
        send_star(rand_star(split_now));
      end
    end

    drain_pipeline();
    if (mismatch_count == 0 && pending == 0) begin
      $display("ic_magnitude_from_bv_polynomial verification clean");
    end else begin
      $display("ic_magnitude_from_bv_polynomial verification failed");
    end
    $finish;
  end

endmodule

@@ ic_magnitude_from_bv_polynomial.f @@
sv/icm_pkg.sv
sv/icm_front.sv
sv/icm_horner_step.sv
sv/icm_back.sv
sv/ic_magnitude_from_bv_polynomial.sv
bench/ic_magnitude_checker.sv
bench/tb_ic_magnitude_from_bv_polynomial.sv
